>>> src/conv2d_pkg.sv
// ---------------------------------------------------------------------------
// conv2d_pkg
// Shared widths, constants and register indexes of the streaming 2D
// fixed-point convolution.
// ---------------------------------------------------------------------------
package conv2d_pkg;

  localparam int PIXEL_W       = 16;
  localparam int COEF_W        = 16;
  localparam int ROW_COEF_W    = 48;
  localparam int CFG_DATA_W    = 48;
  localparam int CFG_INDEX_W   = 3;
  localparam int SIZE_W        = 7;
  localparam int KDIM_W        = 2;
  localparam int POS_W         = 6;
  localparam int KERNEL_MAX    = 3;
  localparam int FRAC_BITS     = 5;
  localparam int MAX_WIDTH_DEF = 64;
  localparam int MIN_SIZE      = 3;
  localparam int SIZE_RESET    = 64;

  typedef logic signed [PIXEL_W-1:0] pixel_t;
  typedef logic [POS_W-1:0]          pos_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_IMAGE_SIZE  = 3'd0,
    REG_KERNEL_ROWS = 3'd1,
    REG_KERNEL_COLS = 3'd2,
    REG_COEF_ROW0   = 3'd3,
    REG_COEF_ROW1   = 3'd4,
    REG_COEF_ROW2   = 3'd5
  } reg_idx_t;

  typedef struct packed {
    logic produce;
    pos_t row;
    pos_t col;
    logic last;
  } tag_t;

endpackage

>>> src/conv2d_stream_if.sv
// ---------------------------------------------------------------------------
// conv2d_stream_if
// Valid/ready channels for pixel requests and convolution results.
// ---------------------------------------------------------------------------
interface conv2d_in_if import conv2d_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t pixel;
  logic   start_of_frame;

  modport source (output valid, output pixel, output start_of_frame, input ready);
  modport sink   (input valid, input pixel, input start_of_frame, output ready);
endinterface

interface conv2d_out_if import conv2d_pkg::*; ();
  logic   valid;
  logic   ready;
  pixel_t conv_value;
  pos_t   out_row;
  pos_t   out_col;
  logic   last_of_frame;

  modport source (output valid, output conv_value, output out_row, output out_col,
                  output last_of_frame, input ready);
  modport sink   (input valid, input conv_value, input out_row, input out_col,
                  input last_of_frame, output ready);
endinterface

>>> src/conv2d_fixed_point_stream.sv
// ---------------------------------------------------------------------------
// conv2d_fixed_point_stream
// Streaming 2D valid correlation of a square raster image against a kernel
// of up to 3x3 taps; line store is one column word of two rows per entry.
// ---------------------------------------------------------------------------
// Each accepted pixel passes stages A, B and C and the output register.
// Throughput: one pixel per cycle unless results stall, set by the single
//   read-modify-write of the line store column word that each pixel performs.
// Reset (sync, active high): configuration to defaults, window, position and
//   pipeline valids cleared; the line store is not cleared.
module conv2d_fixed_point_stream import conv2d_pkg::*; #(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_wr_en,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  conv2d_in_if.sink              pixels,
  conv2d_out_if.source           results
);

  localparam int ADDR_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WORD_W = 2 * PIXEL_W;

  logic [SIZE_W-1:0]     image_size;
  logic [KDIM_W-1:0]     kernel_rows;
  logic [KDIM_W-1:0]     kernel_cols;
  logic [ROW_COEF_W-1:0] coef_row [KERNEL_MAX];

  logic [SIZE_W-1:0] row_count;
  logic [SIZE_W-1:0] col_count;

  logic [WORD_W-1:0] line_mem [MAX_WIDTH];
  logic [WORD_W-1:0] rdata;

  logic              a_valid;
  pixel_t            a_px;
  logic              a_bank;
  logic [ADDR_W-1:0] a_c;
  logic              a_fwd;
  logic [WORD_W-1:0] a_fwd_data;
  tag_t              a_tag;

  logic              b_valid;
  tag_t              b_tag;

  logic              c_valid;
  tag_t              c_tag;
  logic [PIXEL_W-1:0] c_prod [KERNEL_MAX][KERNEL_MAX];

  logic              out_valid;
  pixel_t            out_value;
  tag_t              out_tag;

  logic [PIXEL_W-1:0] win [KERNEL_MAX][KERNEL_MAX];

  logic              adv;
  logic              accept;
  logic [SIZE_W-1:0] size_eff;
  logic [KDIM_W-1:0] kr_eff;
  logic [KDIM_W-1:0] kc_eff;
  logic              wrap;
  logic [SIZE_W-1:0] r_cur;
  logic [SIZE_W-1:0] c_cur;
  logic [SIZE_W-1:0] r_next;
  logic [SIZE_W-1:0] c_next;
  tag_t              tag_cur;
  logic [ADDR_W-1:0] addr_cur;
  logic [WORD_W-1:0] base;
  logic [WORD_W-1:0] wdata;
  logic [PIXEL_W-1:0] top_px;
  logic [PIXEL_W-1:0] mid_px;
  logic [PIXEL_W-1:0] prod [KERNEL_MAX][KERNEL_MAX];
  logic [PIXEL_W-1:0] sum;

  assign adv          = !out_valid || results.ready;
  assign pixels.ready = adv;
  assign accept       = pixels.valid && adv;

  // clamp configuration
  always_comb begin
    if (image_size < SIZE_W'(MIN_SIZE)) begin
      size_eff = SIZE_W'(MIN_SIZE);
    end else if (32'(image_size) > MAX_WIDTH) begin
      size_eff = SIZE_W'(MAX_WIDTH);
    end else begin
      size_eff = image_size;
    end
    if (kernel_rows == '0) begin
      kr_eff = KDIM_W'(1);
    end else if (32'(kernel_rows) > KERNEL_MAX) begin
      kr_eff = KDIM_W'(KERNEL_MAX);
    end else begin
      kr_eff = kernel_rows;
    end
    if (kernel_cols == '0) begin
      kc_eff = KDIM_W'(1);
    end else if (32'(kernel_cols) > KERNEL_MAX) begin
      kc_eff = KDIM_W'(KERNEL_MAX);
    end else begin
      kc_eff = kernel_cols;
    end
  end

  // position of the incoming pixel
  always_comb begin
    wrap  = pixels.start_of_frame || row_count >= size_eff || col_count >= size_eff;
    r_cur = wrap ? '0 : row_count;
    c_cur = wrap ? '0 : col_count;
    if (c_cur + SIZE_W'(1) >= size_eff) begin
      c_next = '0;
      r_next = (r_cur + SIZE_W'(1) >= size_eff) ? '0 : r_cur + SIZE_W'(1);
    end else begin
      c_next = c_cur + SIZE_W'(1);
      r_next = r_cur;
    end
    tag_cur.produce = (r_cur + SIZE_W'(1) >= SIZE_W'(kr_eff)) &&
                      (c_cur + SIZE_W'(1) >= SIZE_W'(kc_eff));
    tag_cur.row     = POS_W'(r_cur + SIZE_W'(1) - SIZE_W'(kr_eff));
    tag_cur.col     = POS_W'(c_cur + SIZE_W'(1) - SIZE_W'(kc_eff));
    tag_cur.last    = (r_cur == size_eff - SIZE_W'(1)) && (c_cur == size_eff - SIZE_W'(1));
    addr_cur        = ADDR_W'(c_cur);
  end

  // merge the new pixel into its column word
  always_comb begin
    base   = a_fwd ? a_fwd_data : rdata;
    top_px = a_bank ? base[WORD_W-1:PIXEL_W] : base[PIXEL_W-1:0];
    mid_px = a_bank ? base[PIXEL_W-1:0] : base[WORD_W-1:PIXEL_W];
    wdata  = a_bank ? {a_px, base[PIXEL_W-1:0]} : {base[WORD_W-1:PIXEL_W], a_px};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      image_size  <= SIZE_W'(SIZE_RESET);
      kernel_rows <= KDIM_W'(KERNEL_MAX);
      kernel_cols <= KDIM_W'(KERNEL_MAX);
      for (int i = 0; i < KERNEL_MAX; i++) begin
        coef_row[i] <= '0;
      end
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_IMAGE_SIZE:  image_size  <= cfg_data[SIZE_W-1:0];
        REG_KERNEL_ROWS: kernel_rows <= cfg_data[KDIM_W-1:0];
        REG_KERNEL_COLS: kernel_cols <= cfg_data[KDIM_W-1:0];
        REG_COEF_ROW0:   coef_row[0] <= cfg_data[ROW_COEF_W-1:0];
        REG_COEF_ROW1:   coef_row[1] <= cfg_data[ROW_COEF_W-1:0];
        REG_COEF_ROW2:   coef_row[2] <= cfg_data[ROW_COEF_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (accept) begin
      row_count <= r_next;
      col_count <= c_next;
    end
  end

  always_ff @(posedge clk) begin
    if (a_valid && adv) begin
      line_mem[a_c] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rdata <= line_mem[addr_cur];
    end
  end

  // stage A: line store read in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= pixels.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      a_px       <= pixels.pixel;
      a_bank     <= r_cur[0];
      a_c        <= addr_cur;
      a_fwd      <= a_valid && (a_c == addr_cur);
      a_fwd_data <= wdata;
      a_tag      <= tag_cur;
    end
  end

  // stage B: shift the window
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
      for (int l = 0; l < KERNEL_MAX; l++) begin
        for (int m = 0; m < KERNEL_MAX; m++) begin
          win[l][m] <= '0;
        end
      end
    end else if (adv) begin
      b_valid <= a_valid;
      if (a_valid) begin
        for (int l = 0; l < KERNEL_MAX; l++) begin
          for (int m = 0; m < KERNEL_MAX - 1; m++) begin
            win[l][m] <= win[l][m+1];
          end
        end
        win[0][KERNEL_MAX-1] <= top_px;
        win[1][KERNEL_MAX-1] <= mid_px;
        win[2][KERNEL_MAX-1] <= a_px;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && a_valid) begin
      b_tag <= a_tag;
    end
  end

  // tap products
  always_comb begin
    logic [KDIM_W-1:0]         l_idx;
    logic [KDIM_W-1:0]         m_idx;
    logic signed [COEF_W-1:0]  cf;
    logic signed [2*PIXEL_W-1:0] full;
    for (int l = 0; l < KERNEL_MAX; l++) begin
      for (int m = 0; m < KERNEL_MAX; m++) begin
        l_idx = KDIM_W'(l) + kr_eff - KDIM_W'(KERNEL_MAX);
        m_idx = KDIM_W'(m) + kc_eff - KDIM_W'(KERNEL_MAX);
        cf    = coef_row[l_idx][m_idx*COEF_W +: COEF_W];
        full  = $signed(win[l][m]) * cf;
        if ((l + 32'(kr_eff) >= KERNEL_MAX) && (m + 32'(kc_eff) >= KERNEL_MAX)) begin
          prod[l][m] = full[FRAC_BITS +: PIXEL_W];
        end else begin
          prod[l][m] = '0;
        end
      end
    end
  end

  // stage C: registered products
  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && b_valid) begin
      c_tag  <= b_tag;
      c_prod <= prod;
    end
  end

  always_comb begin
    sum = '0;
    for (int l = 0; l < KERNEL_MAX; l++) begin
      for (int m = 0; m < KERNEL_MAX; m++) begin
        sum = sum + c_prod[l][m];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= c_valid && c_tag.produce;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && c_valid && c_tag.produce) begin
      out_value <= sum;
      out_tag   <= c_tag;
    end
  end

  assign results.valid         = out_valid;
  assign results.conv_value    = out_value;
  assign results.out_row       = out_tag.row;
  assign results.out_col       = out_tag.col;
  assign results.last_of_frame = out_tag.last;

`ifndef ASSERT_OFF
  a_out_from_stage_c: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(c_valid && c_tag.produce))
    else $error("result raised without a producing item");

  a_stall_holds_a: assert property (@(posedge clk) disable iff (rst)
    a_valid && !adv |=> a_valid && $stable(a_c))
    else $error("line store write lost during stall");

  a_collision_fwd: assert property (@(posedge clk) disable iff (rst)
    accept && a_valid && (a_c == addr_cur) |=> a_fwd)
    else $error("same-column write-back not forwarded");

  a_stall_holds_c: assert property (@(posedge clk) disable iff (rst)
    c_valid && !adv |=> c_valid)
    else $error("item dropped in product stage");
`endif

endmodule
